FILE: rtl/ctsc_pkg.sv
`default_nettype none
package ctsc_pkg;

    localparam int DW        = 64;
    localparam int SEC_W     = 41;
    localparam int NS_W      = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 63;

    localparam int D1_RW = 32;
    localparam int D2_RW = 24;
    localparam int D3_RW = 20;

    localparam logic [9:0]      SCALE_K       = 10'd1000;
    localparam logic [D2_RW-1:0] TICKS_PER_SEC = 24'd10000000;
    localparam logic [D3_RW-1:0] RATIO_DIV     = 20'd1000000;
    localparam logic [6:0]      NS_PER_TICK   = 7'd100;

    // ceil(2^81 / 10^7): (x >> 7) * SEC_RECIP >> 74 == x / 10^7 for any 64-bit x
    localparam logic [57:0] SEC_RECIP = 58'd241785163922925835;
    // ceil(2^78 / 10^6): (x >> 6) * NS_RECIP >> 72 == x / 10^6 for any 64-bit x
    localparam logic [58:0] NS_RECIP  = 59'd302231454903657294;

    localparam logic [SEC_W-1:0] SEC_MAX = 41'd1844674407370;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRACTION_OFFSET = 2'd0,
        CFG_EPOCH_OFFSET    = 2'd1,
        CFG_COUNTS_PER_TICK = 2'd2,
        CFG_NS_PER_COUNT    = 2'd3
    } t_cfg_idx;

endpackage
`default_nettype wire

FILE: rtl/counter_to_timestamp_convert_core.sv
// Counter-to-timestamp converter.
// Input channel: i_valid / o_stall carry one 64-bit counter sample per item;
// an item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry Unix seconds and nanoseconds.
// Config: i_cfg_wr_en, i_cfg_index, i_cfg_data write one register per edge;
// write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The pipeline has
// 64 one-bit restoring divider stages for the ratio division, four stages
// for the seconds and nanosecond divisions done by reciprocal multiplication
// side by side, plus five register stages around them.
// The whole pipeline advances together; while the output register holds an
// item that i_stall blocks, every stage holds and o_stall is raised, so
// nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults: offsets 0, counts per tick 1000, ns per count 100000.
`default_nettype none
module counter_to_timestamp_convert_core #(
    parameter int COUNT_WIDTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [63:0]                   i_counter_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [40:0]                        o_seconds,
    output logic [31:0]                        o_nanoseconds,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [ctsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ctsc_pkg::CFG_W-1:0]    i_cfg_data
);
    import ctsc_pkg::*;

    localparam int NST = DW;

    logic [31:0]   r_frac_off;
    logic [62:0]   r_epoch;
    logic [31:0]   r_cpt;
    logic [31:0]   r_nspc;

    logic          w_en;
    logic [31:0]   w_div1;

    logic                   r_a_v;
    logic [COUNT_WIDTH-1:0] r_a_samp;
    logic                   r_b_v;
    logic [DW-1:0]          r_b_scaled;

    logic             r_d1_v   [NST];
    logic [D1_RW-1:0] r_d1_rem [NST];
    logic [DW-1:0]    r_d1_q   [NST];
    logic [D1_RW-1:0] n_d1_rem [NST];
    logic [DW-1:0]    n_d1_q   [NST];

    logic          r_c_v;
    logic [DW-1:0] r_c_ticks;
    logic [31:0]   r_c_frac;
    logic          r_m_v;
    logic [DW-1:0] r_m_ticks;
    logic [DW-1:0] r_m_prod;

    logic          r_p1_v;
    logic [63:0]   r_p1_t_ll;
    logic [57:0]   r_p1_t_lh;
    logic [56:0]   r_p1_t_hl;
    logic [50:0]   r_p1_t_hh;
    logic [63:0]   r_p1_f_ll;
    logic [58:0]   r_p1_f_lh;
    logic [57:0]   r_p1_f_hl;
    logic [52:0]   r_p1_f_hh;
    logic [23:0]   r_p1_tlow;

    logic          r_p2_v;
    logic [59:0]   r_p2_t_mid;
    logic [50:0]   r_p2_t_hh;
    logic [60:0]   r_p2_f_mid;
    logic [52:0]   r_p2_f_hh;
    logic [23:0]   r_p2_tlow;

    logic          r_p3_v;
    logic [40:0]   r_p3_sec;
    logic [44:0]   r_p3_nsq;
    logic [23:0]   r_p3_tlow;

    logic          r_p4_v;
    logic [40:0]   r_p4_sec;
    logic [44:0]   r_p4_nsq;
    logic [23:0]   r_p4_sub;

    logic [56:0]   w_t_y;
    logic [57:0]   w_f_y;
    logic [50:0]   w_t_top;
    logic [52:0]   w_f_top;
    logic [47:0]   w_qk;
    logic [23:0]   w_sub;

    logic          r_out_v;
    logic [40:0]   r_out_sec;
    logic [31:0]   r_out_ns;
    logic [30:0]   w_sub_ns;
    logic [45:0]   w_ns_sum;

    assign w_en    = !r_out_v || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_out_v;
    assign o_seconds     = r_out_sec;
    assign o_nanoseconds = r_out_ns;
    assign w_div1  = (r_cpt == 32'd0) ? 32'd1 : r_cpt;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_off <= 32'd0;
            r_epoch    <= 63'd0;
            r_cpt      <= 32'd1000;
            r_nspc     <= 32'd100000;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRACTION_OFFSET: r_frac_off <= i_cfg_data[31:0];
                CFG_EPOCH_OFFSET:    r_epoch    <= i_cfg_data;
                CFG_COUNTS_PER_TICK: r_cpt      <= i_cfg_data[31:0];
                CFG_NS_PER_COUNT:    r_nspc     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ratio division: one quotient bit per stage
    always_comb begin
        logic [D1_RW-1:0] s_rem;
        logic [DW-1:0]    s_q;
        logic [D1_RW:0]   t;
        for (int k = 0; k < NST; k++) begin
            s_rem = (k == 0) ? '0 : r_d1_rem[(k == 0) ? 0 : k-1];
            s_q   = (k == 0) ? r_b_scaled : r_d1_q[(k == 0) ? 0 : k-1];
            t     = {s_rem, s_q[DW-1]};
            if (t >= {1'b0, w_div1}) begin
                n_d1_rem[k] = D1_RW'(t - {1'b0, w_div1});
                n_d1_q[k]   = {s_q[DW-2:0], 1'b1};
            end else begin
                n_d1_rem[k] = t[D1_RW-1:0];
                n_d1_q[k]   = {s_q[DW-2:0], 1'b0};
            end
        end
    end

    // seconds split and nanosecond scaling by reciprocal multiplication
    assign w_t_y   = r_m_ticks[63:7];
    assign w_f_y   = r_m_prod[63:6];
    assign w_t_top = 51'(r_p2_t_hh) + 51'(r_p2_t_mid[59:32]);
    assign w_f_top = 53'(r_p2_f_hh) + 53'(r_p2_f_mid[60:32]);
    assign w_qk    = 48'(r_p3_sec[23:0]) * 48'(TICKS_PER_SEC);
    assign w_sub   = r_p3_tlow - w_qk[23:0];

    assign w_sub_ns = 31'(r_p4_sub) * 31'(NS_PER_TICK);
    assign w_ns_sum = 46'(r_p4_nsq) + 46'(w_sub_ns);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < NST; k++) begin
                r_d1_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_a_v     <= i_valid;
            r_b_v     <= r_a_v;
            r_d1_v[0] <= r_b_v;
            for (int k = 1; k < NST; k++) begin
                r_d1_v[k] <= r_d1_v[k-1];
            end
            r_c_v   <= r_d1_v[NST-1];
            r_m_v   <= r_c_v;
            r_p1_v  <= r_m_v;
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_p4_v  <= r_p3_v;
            r_out_v <= r_p4_v;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_samp   <= i_counter_value[COUNT_WIDTH-1:0];
            r_b_scaled <= DW'(r_a_samp) * DW'(SCALE_K) - DW'(r_frac_off);
            for (int k = 0; k < NST; k++) begin
                r_d1_rem[k] <= n_d1_rem[k];
                r_d1_q[k]   <= n_d1_q[k];
            end
            r_c_ticks <= r_d1_q[NST-1] + DW'(r_epoch);
            r_c_frac  <= r_d1_rem[NST-1];
            r_m_ticks <= r_c_ticks;
            r_m_prod  <= DW'(r_c_frac) * DW'(r_nspc);

            r_p1_t_ll <= 64'(w_t_y[31:0]) * 64'(SEC_RECIP[31:0]);
            r_p1_t_lh <= 58'(w_t_y[31:0]) * 58'(SEC_RECIP[57:32]);
            r_p1_t_hl <= 57'(w_t_y[56:32]) * 57'(SEC_RECIP[31:0]);
            r_p1_t_hh <= 51'(w_t_y[56:32]) * 51'(SEC_RECIP[57:32]);
            r_p1_f_ll <= 64'(w_f_y[31:0]) * 64'(NS_RECIP[31:0]);
            r_p1_f_lh <= 59'(w_f_y[31:0]) * 59'(NS_RECIP[58:32]);
            r_p1_f_hl <= 58'(w_f_y[57:32]) * 58'(NS_RECIP[31:0]);
            r_p1_f_hh <= 53'(w_f_y[57:32]) * 53'(NS_RECIP[58:32]);
            r_p1_tlow <= r_m_ticks[23:0];

            r_p2_t_mid <= 60'(r_p1_t_lh) + 60'(r_p1_t_hl) + 60'(r_p1_t_ll[63:32]);
            r_p2_t_hh  <= r_p1_t_hh;
            r_p2_f_mid <= 61'(r_p1_f_lh) + 61'(r_p1_f_hl) + 61'(r_p1_f_ll[63:32]);
            r_p2_f_hh  <= r_p1_f_hh;
            r_p2_tlow  <= r_p1_tlow;

            r_p3_sec  <= w_t_top[50:10];
            r_p3_nsq  <= w_f_top[52:8];
            r_p3_tlow <= r_p2_tlow;

            r_p4_sec <= r_p3_sec;
            r_p4_nsq <= r_p3_nsq;
            r_p4_sub <= w_sub;

            r_out_sec <= r_p4_sec;
            r_out_ns  <= (w_ns_sum[45:32] != 14'd0) ? 32'hFFFF_FFFF : w_ns_sum[31:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ctsc_checker.sv
`default_nettype none
module ctsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [40:0] o_seconds,
    input wire logic [31:0] o_nanoseconds
);
    import ctsc_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_seconds) && $stable(o_nanoseconds))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output blocked");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_seconds <= SEC_MAX)
        else $error("seconds out of range");

endmodule

bind counter_to_timestamp_convert_core ctsc_checker u_ctsc_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_seconds(o_seconds),
    .o_nanoseconds(o_nanoseconds)
);
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ctsc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] counter_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [40:0] seconds;
    logic [31:0] nanoseconds;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRACTION_OFFSET;
    logic [CFG_W-1:0]     cfg_data = '0;

    typedef struct packed {
        logic [40:0] sec;
        logic [31:0] ns;
    } t_stamp;

    logic [63:0] pending_samples[$];
    t_stamp      expected_stamps[$];
    logic [31:0] frac_ofs;
    logic [62:0] epoch_ofs;
    logic [31:0] cnt_per_tick;
    logic [31:0] ns_per_cnt;
    int          errors = 0;
    int          checked = 0;
    int          accepted = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    bit          hold_go = 1'b0;
    bit          hold_on = 1'b0;
    bit          driving_on = 1'b0;

    counter_to_timestamp_convert_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_counter_value(counter_value), .o_valid(out_valid), .i_stall(out_stall),
        .o_seconds(seconds), .o_nanoseconds(nanoseconds), .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic t_stamp convert_sample(logic [63:0] sample);
        logic [63:0] scaled, ticks, frac, sub;
        logic [127:0] nsum;
        t_stamp r;
        scaled = sample * 64'd1000 - {32'd0, frac_ofs};
        if (cnt_per_tick == 0) begin
            ticks = scaled;
            frac = '0;
        end else begin
            ticks = scaled / {32'd0, cnt_per_tick};
            frac = scaled % {32'd0, cnt_per_tick};
        end
        ticks = ticks + {1'b0, epoch_ofs};
        sub = ticks % 64'd10000000;
        nsum = (frac * {32'd0, ns_per_cnt}) / 64'd1000000 + sub * 64'd100;
        r.sec = 41'(ticks / 64'd10000000);
        r.ns = (nsum > 128'hFFFFFFFF) ? 32'hFFFFFFFF : nsum[31:0];
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FRACTION_OFFSET: frac_ofs = val[31:0];
            CFG_EPOCH_OFFSET:    epoch_ofs = val;
            CFG_COUNTS_PER_TICK: cnt_per_tick = val[31:0];
            default:             ns_per_cnt = val[31:0];
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 64'(($urandom_range(0, 1)) ? 64'hFFFFFFFFFFFFFFFF - $urandom_range(0, 99)
                                                 : $urandom_range(0, 99));
            1: return 64'({$urandom} >> $urandom_range(0, 31));
            default: return rand64() >> $urandom_range(0, 63);
        endcase
    endfunction

    // driver: bursts and gaps
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            accepted <= accepted + 1;
            expected_stamps.push_back(convert_sample(counter_value));
        end
        if (!in_valid || !in_stall) begin
            if (driving_on && pending_samples.size() > 0 && gap_left == 0) begin
                in_valid <= 1'b1;
                counter_value <= pending_samples.pop_front();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                end else begin
                    burst_left = burst_left - 1;
                    if (burst_left == 0) gap_left = $urandom_range(0, 8);
                end
            end else begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left = gap_left - 1;
            end
        end
    end

    // long receiver hold-off
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (400) @(posedge clk);
        hold_on <= 1'b0;
    end

    // monitor and receiver stall pattern
    always @(posedge clk) begin
        t_stamp want;
        if (out_valid && !out_stall) begin
            if (expected_stamps.size() == 0) begin
                report_mismatch("unexpected item", {23'd0, seconds}, 64'd0);
            end else begin
                want = expected_stamps.pop_front();
                checked <= checked + 1;
                if (seconds !== want.sec)
                    report_mismatch("seconds", 64'(seconds), 64'(want.sec));
                if (nanoseconds !== want.ns)
                    report_mismatch("nanoseconds", 64'(nanoseconds), 64'(want.ns));
            end
        end
        if (hold_on) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0);
        end
    end

    task automatic run_phase(int n, bit directed_set);
        logic [63:0] d[$];
        if (directed_set) begin
            d = '{64'd0, 64'd1, 64'hFFFFFFFFFFFFFFFF, 64'h8000000000000000,
                  64'h0000000100000000, 64'd999, 64'd1000, 64'd10000000,
                  64'h00418937_4BC6A7EF, 64'h7FFFFFFFFFFFFFFF, 64'hAAAAAAAAAAAAAAAA,
                  64'h5555555555555555};
            foreach (d[i]) pending_samples.push_back(d[i]);
        end
        repeat (n) pending_samples.push_back(rand_sample());
        driving_on = 1'b1;
        while (pending_samples.size() > 0 || in_valid) @(posedge clk);
        while (expected_stamps.size() > 0) @(posedge clk);
        driving_on = 1'b0;
        repeat (150) @(posedge clk);
    endtask

    initial begin
        frac_ofs = '0;
        epoch_ofs = '0;
        cnt_per_tick = 32'd1000;
        ns_per_cnt = 32'd100000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        run_phase(150, 1'b1);
        write_reg(CFG_FRACTION_OFFSET, 63'hFFFFFFFF);
        write_reg(CFG_EPOCH_OFFSET, 63'h7FFFFFFFFFFFFFFF);
        write_reg(CFG_COUNTS_PER_TICK, 63'hFFFFFFFF);
        write_reg(CFG_NS_PER_COUNT, 63'hFFFFFFFF);
        run_phase(200, 1'b1);
        write_reg(CFG_COUNTS_PER_TICK, 63'd0);
        write_reg(CFG_FRACTION_OFFSET, 63'd0);
        write_reg(CFG_EPOCH_OFFSET, 63'd0);
        run_phase(150, 1'b1);
        write_reg(CFG_COUNTS_PER_TICK, 63'd1);
        write_reg(CFG_NS_PER_COUNT, 63'd0);
        run_phase(150, 1'b0);
        // long receiver hold-off while the sender keeps offering items
        hold_go = 1'b1;
        write_reg(CFG_COUNTS_PER_TICK, 63'd1000);
        write_reg(CFG_NS_PER_COUNT, 63'd100000);
        write_reg(CFG_EPOCH_OFFSET, 63'd116444736000000000);
        run_phase(300, 1'b0);
        repeat (8) begin
            write_reg(CFG_FRACTION_OFFSET, 63'({$urandom, $urandom}));
            write_reg(CFG_EPOCH_OFFSET, 63'({$urandom, $urandom} >> $urandom_range(0, 40)));
            write_reg(CFG_COUNTS_PER_TICK, {31'd0, $urandom >> $urandom_range(0, 31)});
            write_reg(CFG_NS_PER_COUNT, 63'({$urandom, $urandom}));
            run_phase(120, 1'b0);
        end
        $display("covered %0d items over 13 register settings incl. zero and max ratio",
                 accepted);
        $display("checked %0d results with random input gaps and output stalls", checked);
        if (errors == 0 && expected_stamps.size() == 0) begin
            $display("PASS counter_to_timestamp_convert_core");
        end else begin
            $display("FAIL counter_to_timestamp_convert_core");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL counter_to_timestamp_convert_core");
        $finish;
    end
endmodule
`default_nettype wire
